// ===== rtl/pau_pkg.sv =====
// shared types and constants of the pixel art upscaler
package pau_pkg;

    localparam int COLOR_W    = 24;
    localparam int SCALE_W    = 2;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int OUT_X_W    = 12;
    localparam int OUT_Y_W    = 14;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 56;

    typedef logic [COLOR_W-1:0] color_t;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // scale modes
    localparam logic [SCALE_W-1:0] MODE_NEAREST2 = 2'd0;
    localparam logic [SCALE_W-1:0] MODE_NEAREST3 = 2'd1;
    localparam logic [SCALE_W-1:0] MODE_EPX      = 2'd2;

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // register reset values
    localparam logic [SCALE_W-1:0]  RST_SCALE_MODE   = MODE_EPX;
    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 12'd1;

endpackage

// ===== rtl/pixel_art_upscaler_unit.sv =====
// pixel art upscaler: nearest 2x, nearest 3x and scale2x/epx over two line buffers
//
//  channel  | ports                           | payload
//  ---------+---------------------------------+----------------------------------------
//  input    | s_tvalid s_tready s_tdata s_tuser | tdata pixel_color, tuser kind
//  result   | m_tvalid m_tready m_tdata m_tlast | tdata out_x out_y out_color,
//           | m_tuser                         | tlast run_end, tuser frame_done
//  config   | cfg_we cfg_addr cfg_wdata       | scale_mode, image_width, image_height
//
// one source pixel gives 4 result pixels (2x, epx) or 9 (3x), one per cycle while
// m_tready is high, so the output serialiser sets the rate; items with no result emit none.
// an accepted item reads both line buffers in the next cycle's read data, is resolved
// into a block register, and a new item is taken while the previous block is emitted.
// synchronous active-low reset clears counters, bank, valids, presets config regs; the line
// buffers are not cleared. a stalled m_tready holds the block and, one item later, s_tready.
module pixel_art_upscaler_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: [23:0] pixel_color
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pau_pkg::S_TDATA_W-1:0]       s_tdata,
    // tuser: [0] kind
    input  logic                                s_tuser,
    // tdata: [11:0] out_x, [25:12] out_y, [49:26] out_color, [55:50] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pau_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast,
    // tuser: [0] frame_done
    output logic                                m_tuser,
    input  logic                                cfg_we,
    input  logic [pau_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [pau_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (CNT_W > pau_pkg::WIDTH_W) ? CNT_W : pau_pkg::WIDTH_W;
    localparam int PAD_W  = pau_pkg::M_TDATA_W - pau_pkg::OUT_X_W - pau_pkg::OUT_Y_W
                            - pau_pkg::COLOR_W;

    // configuration
    logic [pau_pkg::SCALE_W-1:0]  scale_mode_reg;
    logic [pau_pkg::WIDTH_W-1:0]  image_width_reg;
    logic [pau_pkg::HEIGHT_W-1:0] image_height_reg;

    // frame position
    logic                         bank_reg, bank_next;
    logic [ADDR_W-1:0]            column_reg, column_next;
    logic [pau_pkg::HEIGHT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0]             drain_reg, drain_next;

    // line buffers
    pau_pkg::color_t mem_a [MAX_WIDTH];
    pau_pkg::color_t mem_b [MAX_WIDTH];
    pau_pkg::color_t rd_a_reg, rd_b_reg;

    // read stage
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_drain_reg;
    logic                         s1_has_out_reg;
    logic                         s1_first_reg;
    logic                         s1_interior_reg;
    logic                         s1_three_reg;
    logic                         s1_done_reg;
    logic                         s1_bank_reg;
    logic [ADDR_W-1:0]            s1_x_reg;
    logic [pau_pkg::HEIGHT_W-1:0] s1_y_reg;
    pau_pkg::color_t              s1_pix_reg;

    // previous-row window
    pau_pkg::color_t first_pix_reg, win_mid_reg, win_left_reg;

    // block being emitted
    logic                         blk_valid_reg, blk_valid_next;
    logic                         blk_three_reg;
    logic                         blk_done_reg;
    logic [pau_pkg::OUT_X_W-1:0]  blk_bx_reg;
    logic [pau_pkg::OUT_Y_W-1:0]  blk_by_reg;
    pau_pkg::color_t              blk_col_reg [4];
    logic [1:0]                   row_i_reg, row_i_next;
    logic [1:0]                   col_j_reg, col_j_next;

    logic [CMP_W-1:0]             w_ext;
    logic [CNT_W-1:0]             eff_w;
    logic [pau_pkg::HEIGHT_W-1:0] eff_h;
    logic                         s_fire, m_fire;
    logic                         pass_pix, pass_drain, pass_any;
    logic                         rows_done, cols_left, drain_left;
    logic [CNT_W-1:0]             column_inc;
    logic [CNT_W-1:0]             drain_inc;
    logic [ADDR_W-1:0]            prev_addr, cur_addr, addr_a, addr_b;
    logic                         we_a, we_b;
    logic                         cfg_hit;
    logic                         s1_move, blk_free, out_last;
    logic [1:0]                   last_idx;
    pau_pkg::color_t              prev_rd, cur_rd;
    pau_pkg::color_t              p_col, a_col, b_col, c_col, d_col;
    pau_pkg::color_t              col_q [4];
    logic [pau_pkg::OUT_X_W-1:0]  x_ext, bx_calc;
    logic [pau_pkg::OUT_Y_W-1:0]  y_ext, by_calc;
    logic [pau_pkg::OUT_X_W-1:0]  out_x;
    logic [pau_pkg::OUT_Y_W-1:0]  out_y;
    pau_pkg::color_t              out_color;

    // effective frame size
    always_comb begin
        w_ext = CMP_W'(image_width_reg);
        if (w_ext == '0) begin
            eff_w = CNT_W'(1);
        end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
            eff_w = CNT_W'(MAX_WIDTH);
        end else begin
            eff_w = CNT_W'(w_ext);
        end
        eff_h = (image_height_reg == '0) ? pau_pkg::HEIGHT_W'(1) : image_height_reg;
    end

    assign s_tready   = !s1_valid_reg || s1_move;
    assign s_fire     = s_tvalid && s_tready;
    assign rows_done  = (row_reg >= eff_h);
    assign cols_left  = (CNT_W'(column_reg) < eff_w);
    assign drain_left = (drain_reg < eff_w);
    assign pass_pix   = s_fire && (s_tuser == pau_pkg::KIND_PIXEL) && !rows_done && cols_left;
    assign pass_drain = s_fire && (s_tuser == pau_pkg::KIND_DRAIN) && rows_done && drain_left;
    assign pass_any   = pass_pix || pass_drain;
    assign column_inc = CNT_W'(column_reg) + CNT_W'(1);
    assign drain_inc  = drain_reg + CNT_W'(1);
    assign cfg_hit    = cfg_we && (cfg_addr == pau_pkg::CFG_SCALE_MODE
                                   || cfg_addr == pau_pkg::CFG_IMAGE_WIDTH
                                   || cfg_addr == pau_pkg::CFG_IMAGE_HEIGHT);

    // buffer addressing: each row is written over the row two above it, in the same buffer
    assign cur_addr  = column_reg;
    assign prev_addr = pass_drain ? drain_reg[ADDR_W-1:0] : column_reg + ADDR_W'(1);
    assign addr_a    = bank_reg ? prev_addr : cur_addr;
    assign addr_b    = bank_reg ? cur_addr : prev_addr;
    assign we_a      = pass_pix && !bank_reg;
    assign we_b      = pass_pix && bank_reg;

    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem_a[addr_a] <= s_tdata[pau_pkg::COLOR_W-1:0];
        end
        if (pass_any) begin
            rd_a_reg <= mem_a[addr_a];
        end
    end

    always_ff @(posedge aclk) begin
        if (we_b) begin
            mem_b[addr_b] <= s_tdata[pau_pkg::COLOR_W-1:0];
        end
        if (pass_any) begin
            rd_b_reg <= mem_b[addr_b];
        end
    end

    // frame counters
    always_comb begin
        bank_next   = bank_reg;
        column_next = column_reg;
        row_next    = row_reg;
        drain_next  = drain_reg;
        if (cfg_hit) begin
            column_next = '0;
            row_next    = '0;
            drain_next  = '0;
        end else if (pass_pix) begin
            if (column_inc >= eff_w) begin
                column_next = '0;
                bank_next   = !bank_reg;
                row_next    = row_reg + pau_pkg::HEIGHT_W'(1);
            end else begin
                column_next = column_inc[ADDR_W-1:0];
            end
        end else if (pass_drain) begin
            if (drain_inc == eff_w) begin
                column_next = '0;
                row_next    = '0;
                drain_next  = '0;
            end else begin
                drain_next = drain_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_mode_reg   <= pau_pkg::RST_SCALE_MODE;
            image_width_reg  <= pau_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= pau_pkg::RST_IMAGE_HEIGHT;
            bank_reg         <= 1'b0;
            column_reg       <= '0;
            row_reg          <= '0;
            drain_reg        <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    pau_pkg::CFG_SCALE_MODE: begin
                        scale_mode_reg <= cfg_wdata[pau_pkg::SCALE_W-1:0];
                    end
                    pau_pkg::CFG_IMAGE_WIDTH: begin
                        image_width_reg <= cfg_wdata[pau_pkg::WIDTH_W-1:0];
                    end
                    pau_pkg::CFG_IMAGE_HEIGHT: begin
                        image_height_reg <= cfg_wdata[pau_pkg::HEIGHT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            bank_reg   <= bank_next;
            column_reg <= column_next;
            row_reg    <= row_next;
            drain_reg  <= drain_next;
        end
    end

    // read stage capture
    assign s1_valid_next = pass_any || (s1_valid_reg && !s1_move);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pass_any) begin
            s1_drain_reg    <= pass_drain;
            s1_has_out_reg  <= pass_drain || (row_reg != '0);
            s1_first_reg    <= (column_reg == '0);
            s1_interior_reg <= pass_pix && (scale_mode_reg == pau_pkg::MODE_EPX)
                               && (column_reg != '0)
                               && (CNT_W'(column_reg) != eff_w - CNT_W'(1))
                               && (row_reg != pau_pkg::HEIGHT_W'(1));
            s1_three_reg    <= (scale_mode_reg == pau_pkg::MODE_NEAREST3);
            s1_done_reg     <= pass_drain && (drain_inc == eff_w);
            s1_bank_reg     <= bank_reg;
            s1_x_reg        <= pass_drain ? drain_reg[ADDR_W-1:0] : column_reg;
            s1_y_reg        <= pass_drain ? eff_h - pau_pkg::HEIGHT_W'(1)
                                          : row_reg - pau_pkg::HEIGHT_W'(1);
            s1_pix_reg      <= s_tdata[pau_pkg::COLOR_W-1:0];
        end
    end

    // block resolve
    assign last_idx = blk_three_reg ? 2'd2 : 2'd1;
    assign out_last = (row_i_reg == last_idx) && (col_j_reg == last_idx);
    assign m_fire   = blk_valid_reg && m_tready;
    assign blk_free = !blk_valid_reg || (m_fire && out_last);
    assign s1_move  = s1_valid_reg && (!s1_has_out_reg || blk_free);

    assign prev_rd = s1_bank_reg ? rd_a_reg : rd_b_reg;
    assign cur_rd  = s1_bank_reg ? rd_b_reg : rd_a_reg;

    always_comb begin
        if (s1_drain_reg) begin
            p_col = prev_rd;
        end else if (s1_first_reg) begin
            p_col = first_pix_reg;
        end else begin
            p_col = win_mid_reg;
        end
        a_col = cur_rd;
        b_col = prev_rd;
        c_col = win_left_reg;
        d_col = s1_pix_reg;
        if (s1_interior_reg) begin
            col_q[0] = (c_col == a_col && c_col != d_col && a_col != b_col) ? a_col : p_col;
            col_q[1] = (a_col == b_col && a_col != c_col && b_col != d_col) ? b_col : p_col;
            col_q[2] = (d_col == c_col && d_col != b_col && c_col != a_col) ? c_col : p_col;
            col_q[3] = (b_col == d_col && b_col != a_col && d_col != c_col) ? d_col : p_col;
        end else begin
            col_q[0] = p_col;
            col_q[1] = p_col;
            col_q[2] = p_col;
            col_q[3] = p_col;
        end
        // times two is a shift, times three adds the value to the shift
        x_ext   = pau_pkg::OUT_X_W'(s1_x_reg);
        y_ext   = pau_pkg::OUT_Y_W'(s1_y_reg);
        bx_calc = s1_three_reg ? (x_ext << 1) + x_ext : (x_ext << 1);
        by_calc = s1_three_reg ? (y_ext << 1) + y_ext : (y_ext << 1);
    end

    always_ff @(posedge aclk) begin
        if (s1_move && !s1_drain_reg) begin
            win_left_reg <= p_col;
            win_mid_reg  <= b_col;
            if (s1_first_reg) begin
                first_pix_reg <= s1_pix_reg;
            end
        end
        if (s1_move && s1_has_out_reg) begin
            blk_three_reg  <= s1_three_reg;
            blk_done_reg   <= s1_done_reg;
            blk_bx_reg     <= bx_calc;
            blk_by_reg     <= by_calc;
            blk_col_reg[0] <= col_q[0];
            blk_col_reg[1] <= col_q[1];
            blk_col_reg[2] <= col_q[2];
            blk_col_reg[3] <= col_q[3];
        end
    end

    // output serialiser, row-major over the block
    always_comb begin
        blk_valid_next = blk_valid_reg;
        row_i_next     = row_i_reg;
        col_j_next     = col_j_reg;
        if (m_fire) begin
            if (out_last) begin
                blk_valid_next = 1'b0;
                row_i_next     = 2'd0;
                col_j_next     = 2'd0;
            end else if (col_j_reg == last_idx) begin
                col_j_next = 2'd0;
                row_i_next = row_i_reg + 2'd1;
            end else begin
                col_j_next = col_j_reg + 2'd1;
            end
        end
        if (s1_move && s1_has_out_reg) begin
            blk_valid_next = 1'b1;
            row_i_next     = 2'd0;
            col_j_next     = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_valid_reg <= 1'b0;
            row_i_reg     <= 2'd0;
            col_j_reg     <= 2'd0;
        end else begin
            blk_valid_reg <= blk_valid_next;
            row_i_reg     <= row_i_next;
            col_j_reg     <= col_j_next;
        end
    end

    assign out_x     = blk_bx_reg + pau_pkg::OUT_X_W'(col_j_reg);
    assign out_y     = blk_by_reg + pau_pkg::OUT_Y_W'(row_i_reg);
    assign out_color = blk_three_reg ? blk_col_reg[0]
                                     : blk_col_reg[{row_i_reg[0], col_j_reg[0]}];

    assign m_tvalid = blk_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_color, out_y, out_x};
    assign m_tlast  = out_last;
    assign m_tuser  = out_last && blk_done_reg;

endmodule
